// File: hw/rtl/cra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_pkg
// Shared types and constants for the chunk reassembly receiver.
// ----------------------------------------------------------------------------
package cra_pkg;

    localparam int MAX_CHUNKS_DEF = 256;
    localparam logic [31:0] CHUNK_BYTES = 32'd1024;

    typedef enum logic [1:0] {
        CMD_CHUNK   = 2'd0,
        CMD_DONE    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_CONSUME = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        ST_IGNORED   = 3'd0,
        ST_NEW       = 3'd1,
        ST_DUP       = 3'd2,
        ST_COMPLETED = 3'd3,
        ST_RESTART   = 3'd4,
        ST_DONE_OK   = 3'd5,
        ST_HANDED    = 3'd6,
        ST_NONE      = 3'd7
    } status_t;

    typedef struct packed {
        command_t    command;
        logic [31:0] transfer_id;
        logic [31:0] chunk_count;
        logic [31:0] chunk_index;
        logic [31:0] total_size;
        logic [15:0] payload_size;
    } cmd_item_t;

    typedef struct packed {
        status_t     status;
        logic        ack_valid;
        logic [31:0] ack_transfer_id;
        logic [7:0]  ack_chunk_index;
        logic        store_payload;
        logic        request_map;
        logic        map_ready;
    } res_item_t;

endpackage

// File: hw/rtl/cra_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_cmd_if
// Command channel: one beat carries one receiver command.
// ----------------------------------------------------------------------------
interface cra_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] transfer_id;
    logic [31:0] chunk_count;
    logic [31:0] chunk_index;
    logic [31:0] total_size;
    logic [15:0] payload_size;

    modport source (
        output valid, command, transfer_id, chunk_count, chunk_index,
               total_size, payload_size,
        input  ready
    );

    modport sink (
        input  valid, command, transfer_id, chunk_count, chunk_index,
               total_size, payload_size,
        output ready
    );
endinterface

// File: hw/rtl/cra_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_res_if
// Result channel: one beat carries the outcome of one command.
// ----------------------------------------------------------------------------
interface cra_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        ack_valid;
    logic [31:0] ack_transfer_id;
    logic [7:0]  ack_chunk_index;
    logic        store_payload;
    logic        request_map;
    logic        map_ready;

    modport source (
        output valid, status, ack_valid, ack_transfer_id, ack_chunk_index,
               store_payload, request_map, map_ready,
        input  ready
    );

    modport sink (
        input  valid, status, ack_valid, ack_transfer_id, ack_chunk_index,
               store_payload, request_map, map_ready,
        output ready
    );
endinterface

// File: hw/rtl/chunk_reassembly_ack_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_reassembly_ack_receiver_core
// Receive side of a chunked transfer with selective acknowledgement.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the cmd channel, one per beat: chunk, done notice,
// restart request or consume. Every command yields exactly one beat on the
// res channel with a status, the acknowledgement fields, the store and
// request flags and the current map-ready flag.
// A command beat is captured in an input register; when it is processed,
// the transfer state and the result register are written together and the
// result is driven on res from the result register. One command per cycle
// is taken while res does not stall: the bitmap lookup, the byte-sum add and
// the completion compare all fit between the input and result registers.
// When res stalls, the result register holds; one more command waits in the
// input register and cmd ready drops only when both are full.
// Reset clears the transfer state, including the whole chunk bitmap, at
// once, so the block takes commands as soon as reset is released.
// ----------------------------------------------------------------------------
module chunk_reassembly_ack_receiver_core #(
    parameter int MAX_CHUNKS = cra_pkg::MAX_CHUNKS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cra_cmd_if.sink       cmd,
    cra_res_if.source     res
);

    logic               s1_valid_reg, s1_valid_next;
    cra_pkg::cmd_item_t s1_item_reg;
    logic               out_valid_reg, out_valid_next;
    cra_pkg::res_item_t out_item_reg;
    cra_pkg::res_item_t core_result;
    logic               advance;
    logic               accept;

    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || advance;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.command      <= cra_pkg::command_t'(cmd.command);
            s1_item_reg.transfer_id  <= cmd.transfer_id;
            s1_item_reg.chunk_count  <= cmd.chunk_count;
            s1_item_reg.chunk_index  <= cmd.chunk_index;
            s1_item_reg.total_size   <= cmd.total_size;
            s1_item_reg.payload_size <= cmd.payload_size;
        end
        if (advance)
        begin
            out_item_reg <= core_result;
        end
    end

    cra_core #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (s1_item_reg),
        .result (core_result)
    );

    assign res.valid           = out_valid_reg;
    assign res.status          = out_item_reg.status;
    assign res.ack_valid       = out_item_reg.ack_valid;
    assign res.ack_transfer_id = out_item_reg.ack_transfer_id;
    assign res.ack_chunk_index = out_item_reg.ack_chunk_index;
    assign res.store_payload   = out_item_reg.store_payload;
    assign res.request_map     = out_item_reg.request_map;
    assign res.map_ready       = out_item_reg.map_ready;

    // Back pressure reaches cmd only when both registers are occupied.
    a_ready_low_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> s1_valid_reg && out_valid_reg && !res.ready)
        else $error("cmd stalled with room available");

    // A processed command always lands in the result register.
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed command lost");

    // A store request only comes with an acknowledgement of a new chunk.
    a_store_is_new: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.store_payload |->
            out_item_reg.ack_valid &&
            (out_item_reg.status == cra_pkg::ST_NEW ||
             out_item_reg.status == cra_pkg::ST_COMPLETED))
        else $error("store flagged without a new chunk");

endmodule

// File: hw/rtl/cra_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_core
// Transfer state and the combinational update that one command applies to it.
// ----------------------------------------------------------------------------
module cra_core #(
    parameter int MAX_CHUNKS = cra_pkg::MAX_CHUNKS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  cra_pkg::cmd_item_t   item,
    output cra_pkg::res_item_t   result
);

    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam logic [31:0] MAX_W = 32'(MAX_CHUNKS);

    logic [31:0]           cur_reg,   cur_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [31:0]           total_reg, total_next;
    logic [MAX_CHUNKS-1:0] bits_reg,  bits_next;
    logic [CW-1:0]         tally_reg, tally_next;
    logic [31:0]           sum_reg,   sum_next;
    logic                  complete_reg, complete_next;
    logic                  ready_reg,    ready_next;

    logic          chunk_ok;
    logic          adopt;
    logic [CW-1:0] eff_count;
    logic [31:0]   eff_total;
    logic [CW-1:0] eff_tally;
    logic [31:0]   eff_sum;
    logic          eff_bit;
    logic [CW-1:0] tally_inc;
    logic [31:0]   sum_inc;
    logic [IW-1:0] slot;

    assign slot = item.chunk_index[IW-1:0];

    assign chunk_ok = (item.chunk_count != 32'd0) && (item.chunk_count <= MAX_W)
                   && (item.chunk_index < item.chunk_count)
                   && ({16'd0, item.payload_size} <= cra_pkg::CHUNK_BYTES);

    // With no transfer open, a chunk starts one from a clean slate.
    assign adopt     = (cur_reg == 32'd0);
    assign eff_count = adopt ? item.chunk_count[CW-1:0] : count_reg;
    assign eff_total = adopt ? item.total_size : total_reg;
    assign eff_tally = adopt ? '0 : tally_reg;
    assign eff_sum   = adopt ? 32'd0 : sum_reg;
    assign eff_bit   = adopt ? 1'b0 : bits_reg[slot];
    assign tally_inc = eff_tally + 1'b1;
    assign sum_inc   = eff_sum + {16'd0, item.payload_size};

    always_comb
    begin
        cur_next      = cur_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        bits_next     = bits_reg;
        tally_next    = tally_reg;
        sum_next      = sum_reg;
        complete_next = complete_reg;
        ready_next    = ready_reg;

        result.status          = cra_pkg::ST_IGNORED;
        result.ack_valid       = 1'b0;
        result.store_payload   = 1'b0;
        result.request_map     = 1'b0;

        case (item.command)
            cra_pkg::CMD_CHUNK:
            begin
                if (chunk_ok)
                begin
                    if (complete_reg && item.transfer_id == cur_reg)
                    begin
                        result.ack_valid = 1'b1;
                        result.status    = cra_pkg::ST_DUP;
                    end
                    else if (adopt || item.transfer_id == cur_reg)
                    begin
                        if (adopt)
                        begin
                            cur_next      = item.transfer_id;
                            count_next    = item.chunk_count[CW-1:0];
                            total_next    = item.total_size;
                            bits_next     = '0;
                            tally_next    = '0;
                            sum_next      = 32'd0;
                            complete_next = 1'b0;
                            ready_next    = 1'b0;
                        end
                        if (item.chunk_count == 32'(eff_count)
                            && item.total_size == eff_total)
                        begin
                            result.ack_valid = 1'b1;
                            if (eff_bit)
                            begin
                                result.status = cra_pkg::ST_DUP;
                            end
                            else
                            begin
                                bits_next[slot]      = 1'b1;
                                tally_next           = tally_inc;
                                sum_next             = sum_inc;
                                result.store_payload = 1'b1;
                                if (tally_inc == eff_count && sum_inc == eff_total)
                                begin
                                    complete_next = 1'b1;
                                    ready_next    = 1'b1;
                                    result.status = cra_pkg::ST_COMPLETED;
                                end
                                else
                                begin
                                    result.status = cra_pkg::ST_NEW;
                                end
                            end
                        end
                    end
                end
            end
            cra_pkg::CMD_DONE:
            begin
                if (item.transfer_id == cur_reg)
                begin
                    if (!complete_reg || item.total_size != total_reg)
                    begin
                        cur_next           = 32'd0;
                        count_next         = '0;
                        total_next         = 32'd0;
                        bits_next          = '0;
                        tally_next         = '0;
                        sum_next           = 32'd0;
                        complete_next      = 1'b0;
                        ready_next         = 1'b0;
                        result.request_map = 1'b1;
                        result.status      = cra_pkg::ST_RESTART;
                    end
                    else
                    begin
                        result.status = cra_pkg::ST_DONE_OK;
                    end
                end
            end
            cra_pkg::CMD_RESTART:
            begin
                cur_next           = 32'd0;
                count_next         = '0;
                total_next         = 32'd0;
                bits_next          = '0;
                tally_next         = '0;
                sum_next           = 32'd0;
                complete_next      = 1'b0;
                ready_next         = 1'b0;
                result.request_map = 1'b1;
                result.status      = cra_pkg::ST_RESTART;
            end
            cra_pkg::CMD_CONSUME:
            begin
                if (ready_reg)
                begin
                    ready_next    = 1'b0;
                    result.status = cra_pkg::ST_HANDED;
                end
                else
                begin
                    result.status = cra_pkg::ST_NONE;
                end
            end
            default:
            begin
                result.status = cra_pkg::ST_IGNORED;
            end
        endcase

        result.ack_transfer_id = result.ack_valid ? item.transfer_id : 32'd0;
        result.ack_chunk_index = result.ack_valid ? item.chunk_index[7:0] : 8'd0;
        result.map_ready       = ready_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= 32'd0;
            count_reg    <= '0;
            total_reg    <= 32'd0;
            bits_reg     <= '0;
            tally_reg    <= '0;
            sum_reg      <= 32'd0;
            complete_reg <= 1'b0;
            ready_reg    <= 1'b0;
        end
        else if (step)
        begin
            cur_reg      <= cur_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            bits_reg     <= bits_next;
            tally_reg    <= tally_next;
            sum_reg      <= sum_next;
            complete_reg <= complete_next;
            ready_reg    <= ready_next;
        end
    end

    // The ready flag is only ever raised together with completion.
    a_ready_needs_complete: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> complete_reg)
        else $error("ready flag set on an incomplete transfer");

    // The tally always counts the bits set in the bitmap.
    a_tally_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(bits_reg) == int'(tally_reg))
        else $error("tally and bitmap disagree");

    // A stored chunk moves the tally up by one.
    a_store_bumps_tally: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.store_payload |=> tally_reg == $past(tally_inc))
        else $error("store without tally update");

endmodule

// File: tb/chunk_reassembly_ack_receiver_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_reassembly_ack_receiver_core_test
// Drives receiver commands (chunks, done notices, restarts, consumes) through
// the command channel, predicts each outcome with a local copy of the transfer
// state, and checks every result beat field by field, in order, while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module chunk_reassembly_ack_receiver_core_test;

    localparam int NCHUNKS     = cra_pkg::MAX_CHUNKS_DEF;
    localparam int CYCLE_LIMIT = 100000;
    localparam int TAIL_CYCLES = 10;

    logic clk;
    logic rst_n;

    cra_cmd_if cmd_ch();
    cra_res_if res_ch();

    chunk_reassembly_ack_receiver_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // Local copy of the receiver's transfer state.
    logic [31:0]        cur_xfer;
    logic [31:0]        exp_count;
    logic [31:0]        exp_total;
    logic [NCHUNKS-1:0] rx_bits;
    int                 rx_tally;
    logic [31:0]        byte_sum;
    bit                 complete_flag;
    bit                 ready_flag;

    cra_pkg::res_item_t pending_outcomes[$];

    int  err_count;
    int  items_sent;
    int  results_checked;
    int  transfers_run;
    int  reassembled;
    int  cycle_count = 0;
    int  burst_left;
    int  stall_run;
    bit  gaps_on;
    bit  stalls_on;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, pending_outcomes.size());
        $display("chunk_reassembly_ack_receiver_core_test: done, errors");
        $finish;
    end

    function void clear_xfer_state();
        cur_xfer      = '0;
        exp_count     = '0;
        exp_total     = '0;
        rx_bits       = '0;
        rx_tally      = 0;
        byte_sum      = '0;
        complete_flag = 1'b0;
        ready_flag    = 1'b0;
    endfunction

    function automatic cra_pkg::res_item_t receiver_outcome(input cra_pkg::cmd_item_t it);
        cra_pkg::res_item_t r;
        cra_pkg::status_t   st;
        bit                 ack;
        bit                 store;
        bit                 req;
        ack   = 1'b0;
        store = 1'b0;
        req   = 1'b0;
        case (it.command)
            cra_pkg::CMD_CHUNK:
            begin
                if (it.chunk_count == 0 || it.chunk_count > NCHUNKS ||
                    it.chunk_index >= it.chunk_count ||
                    it.payload_size > cra_pkg::CHUNK_BYTES)
                    st = cra_pkg::ST_IGNORED;
                else if (complete_flag && it.transfer_id == cur_xfer)
                begin
                    // A finished transfer still acknowledges its own chunks.
                    ack = 1'b1;
                    st  = cra_pkg::ST_DUP;
                end
                else
                begin
                    if (cur_xfer == 0)
                    begin
                        clear_xfer_state();
                        cur_xfer  = it.transfer_id;
                        exp_count = it.chunk_count;
                        exp_total = it.total_size;
                    end
                    if (cur_xfer != it.transfer_id)
                        st = cra_pkg::ST_IGNORED;
                    else if (it.chunk_count != exp_count || it.total_size != exp_total)
                        st = cra_pkg::ST_IGNORED;
                    else
                    begin
                        ack = 1'b1;
                        if (it.chunk_index >= NCHUNKS)
                            st = cra_pkg::ST_IGNORED;
                        else if (rx_bits[it.chunk_index[7:0]])
                            st = cra_pkg::ST_DUP;
                        else
                        begin
                            rx_bits[it.chunk_index[7:0]] = 1'b1;
                            rx_tally = rx_tally + 1;
                            byte_sum = byte_sum + {16'd0, it.payload_size};
                            store    = 1'b1;
                            if (rx_tally == exp_count && byte_sum == exp_total)
                            begin
                                complete_flag = 1'b1;
                                ready_flag    = 1'b1;
                                st            = cra_pkg::ST_COMPLETED;
                            end
                            else
                                st = cra_pkg::ST_NEW;
                        end
                    end
                end
            end
            cra_pkg::CMD_DONE:
            begin
                if (it.transfer_id != cur_xfer)
                    st = cra_pkg::ST_IGNORED;
                else if (!complete_flag || it.total_size != exp_total)
                begin
                    clear_xfer_state();
                    req = 1'b1;
                    st  = cra_pkg::ST_RESTART;
                end
                else
                    st = cra_pkg::ST_DONE_OK;
            end
            cra_pkg::CMD_RESTART:
            begin
                clear_xfer_state();
                req = 1'b1;
                st  = cra_pkg::ST_RESTART;
            end
            default:
            begin
                if (ready_flag)
                begin
                    ready_flag = 1'b0;
                    st         = cra_pkg::ST_HANDED;
                end
                else
                    st = cra_pkg::ST_NONE;
            end
        endcase
        r.status          = st;
        r.ack_valid       = ack;
        r.ack_transfer_id = ack ? it.transfer_id : 32'd0;
        r.ack_chunk_index = ack ? it.chunk_index[7:0] : 8'd0;
        r.store_payload   = store;
        r.request_map     = req;
        r.map_ready       = ready_flag;
        return r;
    endfunction

    function automatic cra_pkg::cmd_item_t make_cmd(input cra_pkg::command_t c,
                                                    input logic [31:0] tid,
                                                    input logic [31:0] cnt,
                                                    input logic [31:0] idx,
                                                    input logic [31:0] total,
                                                    input logic [15:0] size);
        cra_pkg::cmd_item_t it;
        it.command      = c;
        it.transfer_id  = tid;
        it.chunk_count  = cnt;
        it.chunk_index  = idx;
        it.total_size   = total;
        it.payload_size = size;
        return it;
    endfunction

    // Items that disturb a transfer in progress: garbage, invalid or foreign
    // chunks, mismatched announcements and stray done or consume commands.
    function automatic cra_pkg::cmd_item_t disturbance(input logic [31:0] tid, input int cnt,
                                                       input logic [31:0] total);
        cra_pkg::cmd_item_t it;
        logic [31:0]        c;
        logic [31:0]        idx;
        it = make_cmd(cra_pkg::CMD_CHUNK, tid, cnt, $urandom_range(0, cnt - 1), total,
                      16'($urandom_range(0, 1024)));
        case ($urandom_range(0, 5))
            0:
                it = make_cmd(cra_pkg::command_t'($urandom_range(0, 3)), $urandom,
                              $urandom, $urandom, $urandom,
                              16'($urandom_range(0, 65535)));
            1:
            begin
                case ($urandom_range(0, 3))
                    0: it.chunk_count = 32'd0;
                    1:
                    begin
                        c = $urandom;
                        if (c <= NCHUNKS)
                            c = c + NCHUNKS + 1;
                        it.chunk_count = c;
                    end
                    2:
                    begin
                        idx = $urandom;
                        if (idx < cnt)
                            idx = idx + cnt;
                        it.chunk_index = idx;
                    end
                    default: it.payload_size = 16'($urandom_range(1025, 65535));
                endcase
            end
            2: it.transfer_id = tid ^ ($urandom | 32'd1);
            3:
            begin
                if ($urandom_range(0, 1) == 0 && cnt < NCHUNKS)
                    it.chunk_count = cnt + 1;
                else
                    it.total_size = total ^ (32'd1 << $urandom_range(0, 31));
            end
            4: it = make_cmd(cra_pkg::CMD_CONSUME, $urandom, $urandom, $urandom, $urandom,
                             16'($urandom));
            default:
                it = make_cmd(cra_pkg::CMD_DONE, tid ^ ($urandom | 32'd1), $urandom,
                              $urandom, total, 16'($urandom));
        endcase
        return it;
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            err_count = err_count + 1;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endfunction

    // Result checker: every accepted beat is matched against the oldest prediction.
    always @(posedge clk)
    begin
        cra_pkg::res_item_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                err_count = err_count + 1;
                $display("%0t ns: result beat with no command outstanding, status %0d",
                         $time, res_ch.status);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                results_checked = results_checked + 1;
                compare_field("status", 32'(want.status), 32'(res_ch.status));
                compare_field("ack_valid", 32'(want.ack_valid), 32'(res_ch.ack_valid));
                compare_field("ack_transfer_id", want.ack_transfer_id,
                              res_ch.ack_transfer_id);
                compare_field("ack_chunk_index", 32'(want.ack_chunk_index),
                              32'(res_ch.ack_chunk_index));
                compare_field("store_payload", 32'(want.store_payload),
                              32'(res_ch.store_payload));
                compare_field("request_map", 32'(want.request_map),
                              32'(res_ch.request_map));
                compare_field("map_ready", 32'(want.map_ready), 32'(res_ch.map_ready));
            end
        end
    end

    // Receiver back-pressure: alternating runs of ready and stall of random length.
    always @(negedge clk)
    begin
        if (!rst_n || !stalls_on)
            res_ch.ready = 1'b1;
        else if (stall_run == 0)
        begin
            res_ch.ready = !res_ch.ready;
            stall_run    = res_ch.ready ? $urandom_range(1, 8) : $urandom_range(1, 4);
        end
        else
            stall_run = stall_run - 1;
    end

    task automatic send_cmd(input cra_pkg::cmd_item_t it);
        int gap;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 10);
                repeat (gap)
                begin
                    @(negedge clk);
                    cmd_ch.valid = 1'b0;
                end
            end
            burst_left = burst_left - 1;
        end
        @(negedge clk);
        cmd_ch.command      = it.command;
        cmd_ch.transfer_id  = it.transfer_id;
        cmd_ch.chunk_count  = it.chunk_count;
        cmd_ch.chunk_index  = it.chunk_index;
        cmd_ch.total_size   = it.total_size;
        cmd_ch.payload_size = it.payload_size;
        cmd_ch.valid        = 1'b1;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        pending_outcomes.insert(pending_outcomes.size(), receiver_outcome(it));
        if (pending_outcomes[$].status == cra_pkg::ST_COMPLETED)
            reassembled = reassembled + 1;
        items_sent = items_sent + 1;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_idle_commands();
        send_cmd(make_cmd(cra_pkg::CMD_CONSUME, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0));
        // A done notice for id 0 matches the empty state and forces a restart.
        send_cmd(make_cmd(cra_pkg::CMD_DONE, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0));
        send_cmd(make_cmd(cra_pkg::CMD_DONE, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 16'd0));
        send_cmd(make_cmd(cra_pkg::CMD_RESTART, '1, '1, '1, '1, '1));
    endtask

    task automatic test_invalid_chunks();
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, 32'h11, 32'd0, 32'd0, 32'd10, 16'd10));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, 32'h11, NCHUNKS + 1, 32'd0, 32'd10, 16'd10));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, 32'h11, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'd10, 16'd10));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, 32'h11, 32'd4, 32'd4, 32'd10, 16'd10));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, 32'h11, 32'd4, 32'd0, 32'd10,
                          16'(cra_pkg::CHUNK_BYTES + 1)));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, 32'h11, 32'd4, 32'd0, 32'hFFFF_FFFF,
                          16'hFFFF));
    endtask

    task automatic test_full_transfer();
        logic [31:0] tid;
        tid = 32'hFFFF_FFFF;
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, tid, 32'd3, 32'd2, 32'd1524, 16'd1024));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, tid, 32'd3, 32'd0, 32'd1524, 16'd0));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, tid, 32'd3, 32'd2, 32'd1524, 16'd1024));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, 32'h1234, 32'd3, 32'd1, 32'd1524, 16'd500));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, tid, 32'd4, 32'd1, 32'd1524, 16'd500));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, tid, 32'd3, 32'd1, 32'd1525, 16'd500));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, tid, 32'd3, 32'd1, 32'd1524, 16'd500));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, tid, 32'd3, 32'd0, 32'd1524, 16'd0));
        send_cmd(make_cmd(cra_pkg::CMD_DONE, tid, 32'd0, 32'd0, 32'd1524, 16'd0));
        send_cmd(make_cmd(cra_pkg::CMD_CONSUME, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0));
        send_cmd(make_cmd(cra_pkg::CMD_CONSUME, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0));
        send_cmd(make_cmd(cra_pkg::CMD_DONE, tid, 32'd0, 32'd0, 32'd0, 16'd0));
    endtask

    task automatic test_size_mismatch();
        // Every chunk present but the byte sum falls short of the total.
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, 32'h5A5A, 32'd1, 32'd0, 32'd5, 16'd3));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, 32'h5A5A, 32'd1, 32'd0, 32'd5, 16'd3));
        send_cmd(make_cmd(cra_pkg::CMD_DONE, 32'h5A5A, 32'd0, 32'd0, 32'd5, 16'd0));
    endtask

    task automatic test_null_transfer();
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, 32'd0, 32'd1, 32'd0, 32'd7, 16'd7));
        send_cmd(make_cmd(cra_pkg::CMD_CHUNK, 32'd0, 32'd2, 32'd1, 32'd9, 16'd9));
        send_cmd(make_cmd(cra_pkg::CMD_RESTART, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0));
    endtask

    // One transfer: chunks in random order mixed with duplicates and
    // disturbances, sometimes abandoned early or announced with a wrong total.
    task automatic run_transfer(input bit full_bitmap);
        logic [31:0] tid;
        logic [31:0] total;
        logic [15:0] sizes[$];
        int          order[$];
        int          cnt;
        int          stop_at;
        int          k;
        int          j;
        int          tmp;
        int          pick;
        transfers_run = transfers_run + 1;
        if (cur_xfer != 0 && $urandom_range(0, 9) != 0)
            send_cmd(make_cmd(cra_pkg::CMD_RESTART, $urandom, $urandom, $urandom, $urandom,
                              16'($urandom)));
        tid = $urandom;
        if ($urandom_range(0, 19) == 0)
            tid = 32'd0;
        pick = $urandom_range(0, 9);
        if (full_bitmap)
            cnt = NCHUNKS;
        else if (pick < 7)
            cnt = $urandom_range(1, 6);
        else if (pick < 9)
            cnt = $urandom_range(7, 24);
        else
            cnt = $urandom_range(25, 64);
        total = 32'd0;
        for (k = 0; k < cnt; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                sizes.insert(sizes.size(),
                             $urandom_range(0, 1) ? cra_pkg::CHUNK_BYTES[15:0] : 16'd0);
            else
                sizes.insert(sizes.size(), 16'($urandom_range(0, 1024)));
            total = total + {16'd0, sizes[k]};
            order.insert(order.size(), k);
        end
        if (!full_bitmap && $urandom_range(0, 6) == 0)
            total = total + $urandom_range(1, 50);
        for (k = cnt - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        stop_at = cnt;
        if (!full_bitmap && $urandom_range(0, 7) == 0)
            stop_at = $urandom_range(0, cnt - 1);
        for (k = 0; k < stop_at; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_cmd(disturbance(tid, cnt, total));
            if (k > 0 && $urandom_range(0, 9) == 0)
            begin
                j = order[$urandom_range(0, k - 1)];
                send_cmd(make_cmd(cra_pkg::CMD_CHUNK, tid, cnt, j, total, sizes[j]));
            end
            send_cmd(make_cmd(cra_pkg::CMD_CHUNK, tid, cnt, order[k], total,
                              sizes[order[k]]));
        end
        if (stop_at > 0 && $urandom_range(0, 3) == 0)
            send_cmd(make_cmd(cra_pkg::CMD_CHUNK, tid, cnt, order[0], total,
                              sizes[order[0]]));
        if ($urandom_range(0, 9) != 0)
            send_cmd(make_cmd(cra_pkg::CMD_DONE, tid, $urandom, $urandom,
                              ($urandom_range(0, 4) == 0) ? $urandom : total,
                              16'($urandom)));
        if ($urandom_range(0, 9) < 7)
            send_cmd(make_cmd(cra_pkg::CMD_CONSUME, $urandom, $urandom, $urandom, $urandom,
                              16'($urandom)));
        if ($urandom_range(0, 9) < 3)
            send_cmd(make_cmd(cra_pkg::CMD_CONSUME, $urandom, $urandom, $urandom, $urandom,
                              16'($urandom)));
    endtask

    task automatic test_random_transfers(input int item_goal);
        while (items_sent < item_goal)
        begin
            // Some transfers run with neither side idling.
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            run_transfer(1'b0);
        end
    endtask

    task automatic test_drain_pause();
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        run_transfer(1'b0);
        wait_drain();
        run_transfer(1'b0);
    endtask

    task automatic test_full_bitmap();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        run_transfer(1'b1);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.command      = cra_pkg::CMD_CHUNK;
        cmd_ch.transfer_id  = '0;
        cmd_ch.chunk_count  = '0;
        cmd_ch.chunk_index  = '0;
        cmd_ch.total_size   = '0;
        cmd_ch.payload_size = '0;
        err_count           = 0;
        items_sent          = 0;
        results_checked     = 0;
        transfers_run       = 0;
        reassembled         = 0;
        burst_left          = 0;
        stall_run           = 0;
        gaps_on             = 1'b0;
        stalls_on           = 1'b1;
        clear_xfer_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_commands();
        test_invalid_chunks();
        test_full_transfer();
        test_size_mismatch();
        test_null_transfer();
        test_random_transfers(300);
        test_drain_pause();
        test_full_bitmap();
        test_random_transfers(620);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d commands over %0d random transfers (%0d reassembled);",
                 items_sent, transfers_run, reassembled);
        $display("checked %0d result beats, %0d mismatches.", results_checked, err_count);
        if (err_count == 0)
            $display("chunk_reassembly_ack_receiver_core_test: done, clean");
        else
            $display("chunk_reassembly_ack_receiver_core_test: done, errors");
        $finish;
    end

endmodule
